/* design/dbau_pkg.sv */
`default_nettype none

package dbau_pkg;

  // Fixed field widths and sizes
  localparam int MAX_FDS   = 256;
  localparam int FD_W      = 8;
  localparam int PAYLOAD_W = 16;
  localparam int LIMIT_W   = 9;
  localparam int REQ_W     = 2;
  localparam int STATUS_W  = 2;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_BADF   = 2'd2,
    ST_RSVD   = 2'd3
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;   // latch the incoming transaction
    logic scan;     // examine one map word for allocate
    logic exec;     // free / lookup / unknown request step, issues payload read
    logic look;     // finish lookup with read data
    logic load;     // move result into the output register
  } dbau_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    req_t new_req;  // request type at the input
    req_t req;      // latched request type
    logic hit;      // current map word has a free bit
    logic last;     // current map word is the last one
    logic out_free; // output register can take a result
  } dbau_sts_t;

endpackage

`default_nettype wire

/* design/dbau_ctrl.sv */
`default_nettype none

module dbau_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  dbau_pkg::dbau_sts_t  sts,
  output dbau_pkg::dbau_cmd_t  cmd
);
  import dbau_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_EXEC   = 5'b00100,
    S_LOOK   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = (sts.new_req == REQ_ALLOC) ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit || sts.last) state_nxt = S_FINISH;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = (sts.req == REQ_LOOKUP) ? S_LOOK : S_FINISH;
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/dbau_datapath.sv */
`default_nettype none

module dbau_datapath #(
  parameter int WORD_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // request fields, sampled on cmd.accept
  input  wire logic [dbau_pkg::REQ_W-1:0]      in_req,
  input  wire logic [dbau_pkg::FD_W-1:0]       in_fd,
  input  wire logic [dbau_pkg::PAYLOAD_W-1:0]  in_payload,
  // limit register write
  input  wire logic                            cfg_we,
  input  wire logic [dbau_pkg::LIMIT_W-1:0]    cfg_limit,
  input  dbau_pkg::dbau_cmd_t                  cmd,
  output dbau_pkg::dbau_sts_t                  sts,
  // result register
  input  wire logic                            out_tready,
  output logic                                 out_valid,
  output logic [dbau_pkg::STATUS_W-1:0]        out_status,
  output logic [dbau_pkg::FD_W-1:0]            out_fd,
  output logic [dbau_pkg::PAYLOAD_W-1:0]       out_payload
);
  import dbau_pkg::*;

  // WORD_BITS must be a power of two
  localparam int MAP_WORDS = MAX_FDS / WORD_BITS;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WIDX_W    = FD_W - BIT_W;

  // Free map words and payload store
  logic [WORD_BITS-1:0] map_r [MAP_WORDS];
  logic [WORD_BITS-1:0] map_init [MAP_WORDS];
  logic [PAYLOAD_W-1:0] mem [MAX_FDS];
  logic [PAYLOAD_W-1:0] mem_rd_r;

  // Latched request
  req_t                 req_r;
  logic [FD_W-1:0]      fd_r;
  logic [PAYLOAD_W-1:0] pay_r;
  logic [WIDX_W-1:0]    widx_r;
  logic [LIMIT_W-1:0]   limit_r;

  // Pending result
  status_t              res_status_r;
  logic [FD_W-1:0]      res_fd_r;
  logic [PAYLOAD_W-1:0] res_pay_r;

  // Output register
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [FD_W-1:0]      out_fd_r;
  logic [PAYLOAD_W-1:0] out_pay_r;

  logic [LIMIT_W-1:0]   lim_sat;
  logic [LIMIT_W-1:0]   lim_src;
  logic [WIDX_W-1:0]    map_addr;
  logic [WORD_BITS-1:0] word_rd;
  logic [BIT_W-1:0]     bit_idx;
  logic [FD_W-1:0]      alloc_fd;
  logic                 hit;
  logic                 alloc_ok;
  logic                 in_range;
  logic [WIDX_W-1:0]    fd_word;
  logic [BIT_W-1:0]     fd_bit;
  logic                 do_alloc;
  logic                 do_free;
  logic                 mem_we;
  logic [FD_W-1:0]      mem_wa;
  logic [PAYLOAD_W-1:0] mem_wd;

  // Limit saturation and map rebuild pattern
  assign lim_sat = (cfg_limit > LIMIT_W'(MAX_FDS)) ? LIMIT_W'(MAX_FDS) : cfg_limit;
  assign lim_src = rst_n ? lim_sat : LIMIT_W'(MAX_FDS);

  always_comb begin
    for (int w = 0; w < MAP_WORDS; w++) begin
      for (int b = 0; b < WORD_BITS; b++) begin
        map_init[w][b] = (LIMIT_W'(w * WORD_BITS + b) < lim_src);
      end
    end
  end

  // Single map read port: scan word or the word holding fd
  assign fd_word  = fd_r[FD_W-1:BIT_W];
  assign fd_bit   = fd_r[BIT_W-1:0];
  assign map_addr = cmd.scan ? widx_r : fd_word;
  assign word_rd  = map_r[map_addr];
  assign hit      = |word_rd;

  // Lowest set bit of the word
  always_comb begin
    bit_idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (word_rd[b]) bit_idx = BIT_W'(b);
    end
  end

  assign alloc_fd = {widx_r, bit_idx};
  assign alloc_ok = ({1'b0, alloc_fd} < limit_r);
  assign in_range = ({1'b0, fd_r} < limit_r);
  assign do_alloc = cmd.scan && hit && alloc_ok;
  assign do_free  = cmd.exec && (req_r == REQ_FREE) && in_range;

  // Map update
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      map_r <= map_init;
    end else if (do_alloc) begin
      map_r[widx_r][bit_idx] <= 1'b0;
    end else if (do_free) begin
      map_r[fd_word][fd_bit] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_W'(MAX_FDS);
    end else if (cfg_we) begin
      limit_r <= lim_sat;
    end
  end

  // Payload store: one write, one registered read
  assign mem_we = do_alloc || do_free;
  assign mem_wa = cmd.scan ? alloc_fd : fd_r;
  assign mem_wd = cmd.scan ? pay_r : '0;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd_r <= mem[fd_r];
  end

  // Request latch and scan index
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r  <= req_t'(in_req);
      fd_r   <= in_fd;
      pay_r  <= in_payload;
      widx_r <= '0;
    end else if (cmd.scan && !hit) begin
      widx_r <= widx_r + 1'b1;
    end
  end

  // Result build
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      res_pay_r <= '0;
      if (hit && alloc_ok) begin
        res_status_r <= ST_OK;
        res_fd_r     <= alloc_fd;
      end else begin
        res_status_r <= ST_NOFREE;
        res_fd_r     <= '0;
      end
    end else if (cmd.exec) begin
      res_fd_r     <= fd_r;
      res_pay_r    <= '0;
      res_status_r <= do_free ? ST_OK : ST_BADF;
    end else if (cmd.look) begin
      if (in_range && !word_rd[fd_bit]) begin
        res_status_r <= ST_OK;
        res_pay_r    <= mem_rd_r;
      end
    end
  end

  // Output register, emptied by the downstream transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status_r <= res_status_r;
      out_fd_r     <= res_fd_r;
      out_pay_r    <= res_pay_r;
    end
  end

  assign sts.new_req  = req_t'(in_req);
  assign sts.req      = req_r;
  assign sts.hit      = hit;
  assign sts.last     = (widx_r == WIDX_W'(MAP_WORDS - 1));
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_fd      = out_fd_r;
  assign out_payload = out_pay_r;

endmodule

`default_nettype wire

/* design/descriptor_bitmap_allocator_unit.sv */
// Steps: allocate scans one map word per cycle over 1..MAX_FDS/WORD_BITS words (8 at
//   32-bit words); free runs an exec step; lookup runs exec, then look.
// Throughput: one request at a time, next accepted the cycle after the result is
//   loaded into the output register, which may still be waiting to be taken.
// Reset: limit 256, all descriptors free at once (no clearing pass); the payload
//   store is not initialized, entries are written on allocate and free.
`default_nettype none

module descriptor_bitmap_allocator_unit #(
  parameter int WORD_BITS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // request: tdata = fd_in[7:0], payload_in[23:8]; tuser = req_type[1:0]
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [23:0]                        in_tdata,
  input  wire logic [dbau_pkg::REQ_W-1:0]         in_tuser,
  // result: tdata = fd_out[7:0], payload_out[23:8]; tuser = status[1:0]
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [23:0]                             out_tdata,
  output logic [dbau_pkg::STATUS_W-1:0]           out_tuser,
  // fd_limit write
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [dbau_pkg::LIMIT_W-1:0]       cfg_data
);
  import dbau_pkg::*;

  dbau_cmd_t            cmd;
  dbau_sts_t            sts;
  logic [FD_W-1:0]      out_fd;
  logic [PAYLOAD_W-1:0] out_payload;

  assign cfg_ready = 1'b1;

  dbau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dbau_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_tuser),
    .in_fd       (in_tdata[FD_W-1:0]),
    .in_payload  (in_tdata[FD_W+PAYLOAD_W-1:FD_W]),
    .cfg_we      (cfg_valid),
    .cfg_limit   (cfg_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_tready  (out_tready),
    .out_valid   (out_tvalid),
    .out_status  (out_tuser),
    .out_fd      (out_fd),
    .out_payload (out_payload)
  );

  assign out_tdata = {out_payload, out_fd};

endmodule

`default_nettype wire

/* tb/sv/descriptor_bitmap_allocator_unit_checker.sv */
`default_nettype none

module descriptor_bitmap_allocator_unit_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // request channel: tdata = fd_in[7:0], payload_in[23:8]; tuser = req_type[1:0]
  input  wire logic                           in_tvalid,
  input  wire logic                           in_tready,
  input  wire logic [23:0]                    in_tdata,
  input  wire logic [dbau_pkg::REQ_W-1:0]     in_tuser,
  // result channel: tdata = fd_out[7:0], payload_out[23:8]; tuser = status[1:0]
  input  wire logic                           out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic [23:0]                    out_tdata,
  input  wire logic [dbau_pkg::STATUS_W-1:0]  out_tuser,
  // fd_limit write channel
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [dbau_pkg::LIMIT_W-1:0]   cfg_data,
  output int unsigned                         replies_outstanding,
  output int unsigned                         mismatch_cnt
);
  import dbau_pkg::*;

  localparam int WORD_BITS = 32;
  localparam int MAP_WORDS = MAX_FDS / WORD_BITS;

  typedef struct packed {
    status_t                status;
    logic [FD_W-1:0]        fd;
    logic [PAYLOAD_W-1:0]   handle;
  } reply_t;

  // Shadow copy of the allocator state
  logic [WORD_BITS-1:0] free_words [MAP_WORDS];
  logic [PAYLOAD_W-1:0] handle_store [MAX_FDS];
  int unsigned          fd_limit_q;
  reply_t               replies_due [$];
  reply_t               oldest;
  reply_t               seen;

  initial mismatch_cnt = 0;

  // New limit saturates at MAX_FDS; everything below it becomes free
  function automatic void rebuild_free_map(input logic [LIMIT_W-1:0] limit);
    int unsigned n;
    fd_limit_q = (limit > MAX_FDS) ? MAX_FDS : limit;
    for (n = 0; n < MAX_FDS; n++)
      free_words[n / WORD_BITS][n % WORD_BITS] = (n < fd_limit_q);
  endfunction

  // Apply one request to the shadow state and return the reply it earns
  function automatic reply_t serve_request(input req_t req, input logic [FD_W-1:0] fd,
                                           input logic [PAYLOAD_W-1:0] handle);
    reply_t r;
    logic   in_range;
    logic   found;
    int     w;
    int     b;
    int     n;
    r.status = ST_BADF;
    r.fd     = fd;
    r.handle = '0;
    in_range = (fd < fd_limit_q);
    found    = 1'b0;
    case (req)
      REQ_ALLOC: begin
        r.status = ST_NOFREE;
        r.fd     = '0;
        // first word with any free bit decides, lowest bit wins
        for (w = 0; w < MAP_WORDS && !found; w++) begin
          if (free_words[w] != '0) begin
            found = 1'b1;
            b = 0;
            while (!free_words[w][b]) b++;
            n = w * WORD_BITS + b;
            if (n < fd_limit_q) begin
              free_words[w][b] = 1'b0;
              handle_store[n]  = handle;
              r.status         = ST_OK;
              r.fd             = FD_W'(n);
            end
          end
        end
      end
      REQ_FREE: begin
        if (in_range) begin
          free_words[fd / WORD_BITS][fd % WORD_BITS] = 1'b1;
          handle_store[fd] = '0;
          r.status         = ST_OK;
        end
      end
      REQ_LOOKUP: begin
        if (in_range && !free_words[fd / WORD_BITS][fd % WORD_BITS]) begin
          r.status = ST_OK;
          r.handle = handle_store[fd];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Track transactions on all three channels
  always @(posedge clk) begin
    if (!rst_n) begin
      replies_due.delete();
      rebuild_free_map(LIMIT_W'(MAX_FDS));
      replies_outstanding <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen.status = status_t'(out_tuser);
        seen.fd     = out_tdata[7:0];
        seen.handle = out_tdata[23:8];
        if (replies_due.size() == 0) begin
          $error("unexpected result: status %0d fd_out %0d payload_out 0x%h",
                 seen.status, seen.fd, seen.handle);
          mismatch_cnt++;
        end else begin
          oldest = replies_due.pop_front();
          if (seen.status != oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, seen.status);
            mismatch_cnt++;
          end
          if (seen.fd != oldest.fd) begin
            $error("fd_out: expected %0d, got %0d", oldest.fd, seen.fd);
            mismatch_cnt++;
          end
          if (seen.handle != oldest.handle) begin
            $error("payload_out: expected 0x%h, got 0x%h", oldest.handle, seen.handle);
            mismatch_cnt++;
          end
        end
      end
      if (cfg_valid && cfg_ready)
        rebuild_free_map(cfg_data);
      if (in_tvalid && in_tready)
        replies_due.push_back(serve_request(req_t'(in_tuser), in_tdata[7:0], in_tdata[23:8]));
      replies_outstanding <= replies_due.size();
    end
  end

endmodule

`default_nettype wire

/* tb/sv/descriptor_bitmap_allocator_unit_test.sv */
`default_nettype none

module descriptor_bitmap_allocator_unit_test;
  import dbau_pkg::*;

  localparam int          DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 300000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [23:0]          in_tdata;
  logic [REQ_W-1:0]     in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [23:0]          out_tdata;
  logic [STATUS_W-1:0]  out_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [LIMIT_W-1:0]   cfg_data;
  int unsigned          replies_outstanding;
  int unsigned          mismatch_cnt;
  int unsigned          cycle_cnt;
  logic                 no_idle;

  descriptor_bitmap_allocator_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  descriptor_bitmap_allocator_unit_checker checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_tvalid           (in_tvalid),
    .in_tready           (in_tready),
    .in_tdata            (in_tdata),
    .in_tuser            (in_tuser),
    .out_tvalid          (out_tvalid),
    .out_tready          (out_tready),
    .out_tdata           (out_tdata),
    .out_tuser           (out_tuser),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data),
    .replies_outstanding (replies_outstanding),
    .mismatch_cnt        (mismatch_cnt)
  );

  // Clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Watchdog
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result sink: a fresh stall is drawn after every transaction
  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready)
        stall = no_idle ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // One request transaction; tvalid stays up so a back-to-back item needs no gap
  task automatic send_request(input req_t req, input logic [FD_W-1:0] fd,
                              input logic [PAYLOAD_W-1:0] handle);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {handle, fd};
    in_tuser  <= req;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Hold requests until every reply is back and the unit has settled
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (replies_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] limit);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= limit;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly descriptors inside the limit so lookups and frees hit live entries
  task automatic random_request(input int unsigned lim);
    int unsigned      roll;
    req_t             req;
    logic [FD_W-1:0]  fd;
    roll = $urandom_range(0, 99);
    if (roll < 40)      req = REQ_ALLOC;
    else if (roll < 65) req = REQ_FREE;
    else if (roll < 95) req = REQ_LOOKUP;
    else                req = REQ_NONE;
    if (lim != 0 && $urandom_range(0, 9) < 7)
      fd = FD_W'($urandom_range(0, lim - 1));
    else
      fd = FD_W'($urandom);
    send_request(req, fd, PAYLOAD_W'($urandom));
  endtask

  initial begin : stimulus
    int unsigned lim;
    int          p;
    no_idle   = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= REQ_ALLOC;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: full range after reset
    send_request(REQ_LOOKUP, 8'd0, 16'h0000);   // lookup of a free descriptor
    send_request(REQ_FREE, 8'd255, 16'h1234);   // free of an already free one
    send_request(REQ_ALLOC, 8'hFF, 16'hFFFF);
    send_request(REQ_ALLOC, 8'h00, 16'h0000);
    send_request(REQ_LOOKUP, 8'd0, 16'h0000);
    send_request(REQ_LOOKUP, 8'd1, 16'hFFFF);
    send_request(REQ_LOOKUP, 8'd255, 16'h0000);
    send_request(REQ_NONE, 8'hAA, 16'h5555);    // unknown request type
    send_request(REQ_FREE, 8'd0, 16'h0000);
    send_request(REQ_LOOKUP, 8'd0, 16'h0000);
    send_request(REQ_ALLOC, 8'd0, 16'hA5A5);    // reuses the lowest number

    // Directed: zero limit, nothing valid
    write_limit(9'd0);
    send_request(REQ_ALLOC, 8'd0, 16'h1111);
    send_request(REQ_FREE, 8'd0, 16'h0000);
    send_request(REQ_LOOKUP, 8'd0, 16'h0000);
    send_request(REQ_NONE, 8'd255, 16'hFFFF);

    // Directed: single descriptor, exhaustion and out-of-range free
    write_limit(9'd1);
    send_request(REQ_ALLOC, 8'd0, 16'h8001);
    send_request(REQ_ALLOC, 8'd0, 16'h7FFE);
    send_request(REQ_LOOKUP, 8'd0, 16'h0000);
    send_request(REQ_FREE, 8'd1, 16'h0000);
    send_request(REQ_LOOKUP, 8'd255, 16'h0000);
    send_request(REQ_FREE, 8'd0, 16'h0000);
    send_request(REQ_LOOKUP, 8'd0, 16'h0000);

    // Random phases across limit settings, saturation included
    for (p = 0; p < 8; p++) begin
      case (p)
        0:       lim = 256;
        1:       lim = $urandom_range(1, 256);
        2:       lim = 8;
        3:       lim = 1;
        4:       lim = 33;
        5:       lim = 511;
        6:       lim = $urandom_range(2, 40);
        default: lim = 32;
      endcase
      write_limit(LIMIT_W'(lim));
      no_idle = (p == 4);
      if (lim > MAX_FDS) lim = MAX_FDS;
      repeat (100) random_request(lim);
    end

    drain();
    if (mismatch_cnt == 0 && replies_outstanding == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
